/* rtl/core/assert_macros.svh */
// Shared assertion macros for the deframer checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define APD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("deframer check failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define APD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  `APD_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

/* rtl/core/apd_pkg.sv */
`default_nettype none

package apd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 16;
  localparam int unsigned CountW    = 32;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CfgIndexW = 8;

  localparam logic [ByteW-1:0] SyncByte = 8'hFF;
  localparam logic [ByteW:0]   CsumMod  = 9'd255;

  typedef enum logic [KindW-1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_IDREJ = 2'd3
  } kind_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_PEER_ID = 8'd0,
    CFG_OWN_ID  = 8'd1
  } cfg_index_e;

endpackage

`default_nettype wire

/* rtl/core/addressed_packet_deframer.sv */
// Channel  | Direction | Handshake             | Beat contents
// ---------+-----------+-----------------------+--------------------------------------
// in       | input     | in_valid_i/in_stall_o | rx_byte_i
// out      | output    | out_valid_o/out_stall_i | kind_o, payload_byte_o, byte_index_o,
//          |           |                       | frame_length_o, good_frames_o
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte is taken per cycle when not stalled; its result, if any, is registered.
// The frame parser state and the 8-bit modulo-255 sum update in the accepting cycle.
// A two-entry output register and skid stage hold results; input stalls only when
// the skid stage is full. Configuration writes are always ready.
// Reset returns the parser to hunting for the first sync byte and clears the count.
`default_nettype none

module addressed_packet_deframer import apd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [ByteW-1:0]     rx_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [KindW-1:0]          kind_o,
  output logic [ByteW-1:0]          payload_byte_o,
  output logic [LenW-1:0]           byte_index_o,
  output logic [LenW-1:0]           frame_length_o,
  output logic [CountW-1:0]         good_frames_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [ByteW-1:0]     cfg_data_i
);

  typedef enum logic [7:0] {
    PH_SYNC1  = 8'b0000_0001,
    PH_SYNC2  = 8'b0000_0010,
    PH_SENDER = 8'b0000_0100,
    PH_RECVR  = 8'b0000_1000,
    PH_LENH   = 8'b0001_0000,
    PH_LENL   = 8'b0010_0000,
    PH_DATA   = 8'b0100_0000,
    PH_CHECK  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  pbyte;
    logic [LenW-1:0]   index;
    logic [LenW-1:0]   length;
    logic [CountW-1:0] count;
  } result_t;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   cnt_q, cnt_d;
  logic [CountW-1:0] frames_q, frames_d;
  logic [ByteW-1:0]  peer_id_q, own_id_q;

  logic              out_valid_q, skid_valid_q;
  result_t           out_q, skid_q;

  logic              in_fire, out_fire;
  logic              res_valid;
  kind_e             res_kind;
  logic [ByteW-1:0]  res_byte;
  logic [LenW-1:0]   res_index;
  result_t           res;

  logic [ByteW:0]    sum_ext;
  logic [ByteW:0]    sum_red;
  logic [ByteW-1:0]  sum_add;
  logic [ByteW-1:0]  sum_first;
  logic [LenW-1:0]   cnt_inc;
  logic [LenW-1:0]   len_full;

  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign cfg_ready_o = 1'b1;

  assign sum_ext   = {1'b0, sum_q} + {1'b0, rx_byte_i};
  assign sum_red   = (sum_ext >= CsumMod) ? (sum_ext - CsumMod) : sum_ext;
  assign sum_add   = sum_red[ByteW-1:0];
  assign sum_first = (rx_byte_i == SyncByte) ? 8'd0 : rx_byte_i;
  assign cnt_inc   = cnt_q + 16'd1;
  assign len_full  = {len_q[LenW-1:ByteW], rx_byte_i};

  always_comb begin
    phase_d   = phase_q;
    sum_d     = sum_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    frames_d  = frames_q;
    res_valid = 1'b0;
    res_kind  = KIND_DATA;
    res_byte  = '0;
    res_index = '0;
    case (phase_q)
      PH_SYNC1: begin
        if (rx_byte_i == SyncByte) begin
          sum_d   = sum_first;
          len_d   = '0;
          cnt_d   = '0;
          phase_d = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (rx_byte_i == SyncByte) begin
          sum_d   = sum_add;
          phase_d = PH_SENDER;
        end else begin
          phase_d = PH_SYNC1;
        end
      end
      PH_SENDER: begin
        if (rx_byte_i == peer_id_q) begin
          sum_d   = sum_add;
          phase_d = PH_RECVR;
        end else begin
          phase_d   = PH_SYNC1;
          res_valid = 1'b1;
          res_kind  = KIND_IDREJ;
        end
      end
      PH_RECVR: begin
        if (rx_byte_i == own_id_q) begin
          sum_d   = sum_add;
          phase_d = PH_LENH;
        end else begin
          phase_d   = PH_SYNC1;
          res_valid = 1'b1;
          res_kind  = KIND_IDREJ;
        end
      end
      PH_LENH: begin
        sum_d   = sum_add;
        len_d   = {rx_byte_i, 8'd0};
        phase_d = PH_LENL;
      end
      PH_LENL: begin
        sum_d   = sum_add;
        len_d   = len_full;
        phase_d = (len_full == '0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        sum_d     = sum_add;
        cnt_d     = cnt_inc;
        phase_d   = (cnt_inc >= len_q) ? PH_CHECK : PH_DATA;
        res_valid = 1'b1;
        res_kind  = KIND_DATA;
        res_byte  = rx_byte_i;
        res_index = cnt_q;
      end
      PH_CHECK: begin
        phase_d   = PH_SYNC1;
        res_valid = 1'b1;
        if (rx_byte_i == sum_q) begin
          frames_d = frames_q + 32'd1;
          res_kind = KIND_GOOD;
        end else begin
          res_kind = KIND_BAD;
        end
      end
      default: begin
        phase_d = PH_SYNC1;
      end
    endcase
  end

  assign res = '{kind: res_kind, pbyte: res_byte, index: res_index,
                 length: len_q, count: frames_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SYNC1;
      sum_q     <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      frames_q  <= '0;
      peer_id_q <= '0;
      own_id_q  <= '0;
    end else begin
      if (in_fire) begin
        phase_q  <= phase_d;
        sum_q    <= sum_d;
        len_q    <= len_d;
        cnt_q    <= cnt_d;
        frames_q <= frames_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_PEER_ID) begin
          peer_id_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_OWN_ID) begin
          own_id_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire || !out_valid_q) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire && res_valid;
        end
      end else if (in_fire && res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire && res_valid) begin
        out_q <= res;
      end
    end else if (in_fire && res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign payload_byte_o = out_q.pbyte;
  assign byte_index_o   = out_q.index;
  assign frame_length_o = out_q.length;
  assign good_frames_o  = out_q.count;

endmodule

`default_nettype wire

/* rtl/core/apd_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module apd_checker import apd_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [KindW-1:0]     kind_o,
  input wire logic [ByteW-1:0]     payload_byte_o,
  input wire logic [LenW-1:0]      byte_index_o,
  input wire logic [LenW-1:0]      frame_length_o,
  input wire logic [CountW-1:0]    good_frames_o
);

  logic out_is_data;
  logic out_is_idrej;

  assign out_is_data  = out_valid_o && (kind_o == KIND_DATA);
  assign out_is_idrej = out_valid_o && (kind_o == KIND_IDREJ);

  // A stalled result beat holds its contents until taken.
  `APD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(kind_o) && $stable(payload_byte_o) &&
    $stable(byte_index_o) && $stable(frame_length_o) && $stable(good_frames_o))

  // Only payload beats carry a byte value and a position.
  `APD_ASSERT(a_ctrl_zero, clk_i, rst_ni,
    (out_valid_o && !out_is_data) |-> (payload_byte_o == '0 && byte_index_o == '0))

  // A payload position always lies inside the announced length.
  `APD_ASSERT(a_index_range, clk_i, rst_ni,
    out_is_data |-> (byte_index_o < frame_length_o))

  // An id rejection comes before the length field is received.
  `APD_ASSERT(a_idrej_len, clk_i, rst_ni,
    out_is_idrej |-> (frame_length_o == '0))

endmodule

bind addressed_packet_deframer apd_checker u_apd_checker (.*);

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import apd_pkg::*;

  localparam int unsigned RandomBytes = 1700;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam logic [CfgIndexW-1:0] CfgUnused = 8'd2;
  localparam logic [CfgIndexW-1:0] CfgIndexMax = 8'hFF;

  typedef enum logic [2:0] {
    HUNT_SYNC1,
    HUNT_SYNC2,
    GET_SENDER,
    GET_RECEIVER,
    GET_LEN_HI,
    GET_LEN_LO,
    GET_PAYLOAD,
    GET_CHECKSUM
  } deframe_phase_e;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  pbyte;
    logic [LenW-1:0]   index;
    logic [LenW-1:0]   length;
    logic [CountW-1:0] frames;
  } result_t;

  typedef enum logic {ROW_RX, ROW_CFG} row_op_e;

  typedef struct {
    row_op_e          op;
    logic [ByteW-1:0] value;
    logic [ByteW-1:0] data;
    bit               typed;
    result_t          res;
  } script_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [ByteW-1:0]     rx_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [KindW-1:0]     kind_o;
  logic [ByteW-1:0]     payload_byte_o;
  logic [LenW-1:0]      byte_index_o;
  logic [LenW-1:0]      frame_length_o;
  logic [CountW-1:0]    good_frames_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [ByteW-1:0]     cfg_data_i = '0;

  deframe_phase_e    rx_phase = HUNT_SYNC1;
  logic [ByteW-1:0]  rx_sum = '0;
  logic [LenW-1:0]   rx_len = '0;
  logic [LenW:0]     rx_count = '0;
  logic [CountW-1:0] good_count = '0;
  logic [ByteW-1:0]  peer_cfg = '0;
  logic [ByteW-1:0]  own_cfg = '0;

  result_t     frame_results [$];
  bit          use_typed = 1'b0;
  result_t     typed_result = '0;
  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned stuck_cycles = 0;
  int unsigned bytes_sent = 0;

  addressed_packet_deframer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o),
    .good_frames_o  (good_frames_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 34);
  end

  function automatic logic [ByteW-1:0] add_mod255(logic [ByteW-1:0] acc, logic [ByteW-1:0] b);
    logic [ByteW:0] s;
    s = {1'b0, acc} + {1'b0, b};
    if (s >= CsumMod) begin
      s = s - CsumMod;
    end
    return s[ByteW-1:0];
  endfunction

  task automatic deframe_byte(input logic [ByteW-1:0] b, output bit produced,
                              output result_t res);
    produced = 1'b0;
    res = '0;
    case (rx_phase)
      HUNT_SYNC1: begin
        if (b == SyncByte) begin
          rx_len = '0;
          rx_count = '0;
          rx_sum = add_mod255('0, b);
          rx_phase = HUNT_SYNC2;
        end
      end
      HUNT_SYNC2: begin
        if (b == SyncByte) begin
          rx_sum = add_mod255(rx_sum, b);
          rx_phase = GET_SENDER;
        end else begin
          rx_phase = HUNT_SYNC1;
        end
      end
      GET_SENDER, GET_RECEIVER: begin
        if (b == ((rx_phase == GET_SENDER) ? peer_cfg : own_cfg)) begin
          rx_sum = add_mod255(rx_sum, b);
          rx_phase = (rx_phase == GET_SENDER) ? GET_RECEIVER : GET_LEN_HI;
        end else begin
          rx_phase = HUNT_SYNC1;
          produced = 1'b1;
          res.kind = KIND_IDREJ;
        end
      end
      GET_LEN_HI: begin
        rx_sum = add_mod255(rx_sum, b);
        rx_len = {b, 8'h00};
        rx_phase = GET_LEN_LO;
      end
      GET_LEN_LO: begin
        rx_sum = add_mod255(rx_sum, b);
        rx_len[7:0] = b;
        rx_phase = (rx_len == '0) ? GET_CHECKSUM : GET_PAYLOAD;
      end
      GET_PAYLOAD: begin
        rx_sum = add_mod255(rx_sum, b);
        produced = 1'b1;
        res.kind = KIND_DATA;
        res.pbyte = b;
        res.index = rx_count[LenW-1:0];
        rx_count = rx_count + {{LenW{1'b0}}, 1'b1};
        if (rx_count >= {1'b0, rx_len}) begin
          rx_phase = GET_CHECKSUM;
        end
      end
      default: begin
        rx_phase = HUNT_SYNC1;
        produced = 1'b1;
        if (b == rx_sum) begin
          good_count = good_count + 32'd1;
          res.kind = KIND_GOOD;
        end else begin
          res.kind = KIND_BAD;
        end
      end
    endcase
    res.length = rx_len;
    res.frames = good_count;
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // A result beat is checked against the oldest expectation.
  always @(posedge clk_i) begin : scoreboard
    bit      produced;
    bit      took_in;
    bit      took_out;
    bit      took_cfg;
    result_t predicted;
    result_t want;
    if (rst_ni) begin
      took_cfg = cfg_valid_i && cfg_ready_o;
      took_in = in_valid_i && !in_stall_o;
      took_out = out_valid_o && !out_stall_i;
      if (took_cfg) begin
        case (cfg_index_i)
          CFG_PEER_ID: peer_cfg = cfg_data_i;
          CFG_OWN_ID:  own_cfg = cfg_data_i;
          default: ;
        endcase
      end
      if (took_in) begin
        deframe_byte(rx_byte_i, produced, predicted);
        if (use_typed) begin
          frame_results.push_back(typed_result);
        end else if (produced) begin
          frame_results.push_back(predicted);
        end
      end
      if (took_out) begin
        if (frame_results.size() == 0) begin
          $display("%0t: expected no result beat, actual beat of kind %0d", $time, kind_o);
          mismatches++;
        end else begin
          want = frame_results.pop_front();
          compare_field("kind", 32'(want.kind), 32'(kind_o));
          compare_field("payload_byte", 32'(want.pbyte), 32'(payload_byte_o));
          compare_field("byte_index", 32'(want.index), 32'(byte_index_o));
          compare_field("frame_length", 32'(want.length), 32'(frame_length_o));
          compare_field("good_frames", want.frames, good_frames_o);
        end
      end
      stuck_cycles = (took_in || took_cfg) ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] value, input bit typed,
                           input result_t typed_res);
    bit sent;
    sent = 1'b0;
    while (!sent) begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 99) < 34) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        rx_byte_i <= value;
        use_typed <= typed;
        typed_result <= typed_res;
        do @(posedge clk_i); while (in_stall_o);
        sent = 1'b1;
      end
    end
    bytes_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (frame_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] index, input logic [ByteW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic script_row_t rx(logic [ByteW-1:0] b);
    return '{op: ROW_RX, value: b, data: '0, typed: 1'b0, res: '0};
  endfunction

  function automatic script_row_t rx_exp(logic [ByteW-1:0] b, kind_e k, logic [ByteW-1:0] pb,
                                         logic [LenW-1:0] idx, logic [LenW-1:0] len,
                                         logic [CountW-1:0] frames);
    result_t r;
    r.kind = k;
    r.pbyte = pb;
    r.index = idx;
    r.length = len;
    r.frames = frames;
    return '{op: ROW_RX, value: b, data: '0, typed: 1'b1, res: r};
  endfunction

  function automatic script_row_t wr(logic [CfgIndexW-1:0] index, logic [ByteW-1:0] data);
    return '{op: ROW_CFG, value: index, data: data, typed: 1'b0, res: '0};
  endfunction

  function automatic logic [ByteW-1:0] pick_id();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    script_row_t      script [$];
    logic [ByteW-1:0] header [$];
    logic [ByteW-1:0] csum;
    logic [ByteW-1:0] v;
    logic [LenW-1:0]  len;
    int unsigned      pick;

    script = '{
      rx(8'hFF), rx(8'hFF), rx(8'h00), rx(8'h00), rx(8'h00), rx(8'h01),
      rx_exp(8'hAB, KIND_DATA, 8'hAB, 16'd0, 16'd1, 32'd0),
      rx_exp(8'hAC, KIND_GOOD, 8'h00, 16'd0, 16'd1, 32'd1),
      rx(8'hFF), rx(8'hFF), rx(8'h00), rx(8'h00), rx(8'h00), rx(8'h00),
      rx_exp(8'h00, KIND_GOOD, 8'h00, 16'd0, 16'd0, 32'd2),
      rx(8'hFF), rx(8'h12),
      rx(8'hFF), rx(8'hFF),
      rx_exp(8'h05, KIND_IDREJ, 8'h00, 16'd0, 16'd0, 32'd2),
      wr(CFG_PEER_ID, 8'hFF), wr(CFG_OWN_ID, 8'hFF), wr(CfgUnused, 8'h5A),
      rx(8'hFF), rx(8'hFF), rx(8'hFF), rx(8'hFF), rx(8'h00), rx(8'h01), rx(8'h80),
      rx_exp(8'h7F, KIND_BAD, 8'h00, 16'd0, 16'd1, 32'd2),
      rx(8'hFF), rx(8'hFF), rx(8'hFF),
      rx_exp(8'h00, KIND_IDREJ, 8'h00, 16'd0, 16'd0, 32'd2)
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].op == ROW_CFG) begin
        if (i > 0 && script[i-1].op == ROW_RX) begin
          drain();
        end
        write_reg(script[i].value, script[i].data);
      end else begin
        send_byte(script[i].value, script[i].typed, script[i].res);
      end
    end

    bytes_sent = 0;
    while (bytes_sent < RandomBytes) begin
      calm = (bytes_sent > 800) && (bytes_sent < 1150);
      if ($urandom_range(0, 99) < 5) begin
        drain();
        write_reg(CFG_PEER_ID, pick_id());
        write_reg(CFG_OWN_ID, pick_id());
        if ($urandom_range(0, 1) == 1) begin
          write_reg(CfgIndexW'($urandom_range(CfgUnused, CfgIndexMax)),
                    8'($urandom_range(0, 255)));
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        case ($urandom_range(0, 49))
          0: len = LenW'($urandom_range(13, 600));
          1, 2, 3, 4, 5: len = LenW'($urandom_range(13, 40));
          default: len = LenW'($urandom_range(0, 12));
        endcase
        header = '{SyncByte, SyncByte, peer_cfg, own_cfg, len[15:8], len[7:0]};
        csum = '0;
        foreach (header[j]) begin
          send_byte(header[j], 1'b0, '0);
          csum = add_mod255(csum, header[j]);
        end
        for (int j = 0; j < len; j++) begin
          v = 8'($urandom_range(0, 255));
          send_byte(v, 1'b0, '0);
          csum = add_mod255(csum, v);
        end
        if ($urandom_range(0, 99) < 15) begin
          csum = csum + 8'($urandom_range(1, 255));
        end
        send_byte(csum, 1'b0, '0);
      end else if (pick < 75) begin
        send_byte(SyncByte, 1'b0, '0);
        send_byte(SyncByte, 1'b0, '0);
        if ($urandom_range(0, 1) == 1) begin
          do v = 8'($urandom_range(0, 255)); while (v == peer_cfg);
          send_byte(v, 1'b0, '0);
        end else begin
          send_byte(peer_cfg, 1'b0, '0);
          do v = 8'($urandom_range(0, 255)); while (v == own_cfg);
          send_byte(v, 1'b0, '0);
        end
      end else if (pick < 88) begin
        send_byte(SyncByte, 1'b0, '0);
        send_byte(8'($urandom_range(0, 254)), 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(8'($urandom_range(0, 254)), 1'b0, '0);
        end
      end
    end

    calm = 1'b0;
    drain();
    if (mismatches == 0 && frame_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/apd_pkg.sv
rtl/core/addressed_packet_deframer.sv
rtl/core/apd_checker.sv
sim/tb_top.sv
